/* sv/multichannel_moving_average_top_macros.svh */
// Assertion macros shared by the moving-average filter RTL.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average check failed");

`endif

/* sv/mma_pkg.sv */
// Shared widths and types for the multichannel moving-average filter.
`default_nettype none

package mma_pkg;

    localparam int CHAN_W    = 4;
    localparam int SAMPLE_W  = 10;
    localparam int SUM_OUT_W = 13;

    // Control produced by the per-channel state update.
    typedef struct packed {
        logic ring_we;
        logic primed_now;
    } mma_upd_t;

endpackage

`default_nettype wire

/* sv/mma_chan_state.sv */
// Per-channel window state and the single-pass sum update.
`default_nettype none

module mma_chan_state #(
    parameter int CHANNELS = 10,
    parameter int WINDOW   = 8,
    localparam int POS_W   = $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          upd_en,
    input  wire logic [mma_pkg::CHAN_W-1:0]    upd_chan,
    input  wire logic [mma_pkg::SAMPLE_W-1:0]  upd_sample,
    input  wire logic [mma_pkg::SAMPLE_W-1:0]  ring_rdata,
    input  wire logic [mma_pkg::CHAN_W-1:0]    look_chan,
    output logic      [POS_W-1:0]              look_pos,
    output logic      [POS_W-1:0]              upd_pos,
    output mma_pkg::mma_upd_t                  upd_ctl,
    output logic      [mma_pkg::SUM_OUT_W-1:0] upd_sum
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = mma_pkg::SAMPLE_W + POS_W;
    localparam logic [mma_pkg::CHAN_W:0] CHAN_LIMIT = (mma_pkg::CHAN_W + 1)'(CHANNELS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

    logic [SUM_W-1:0]             sum_reg      [CHANNELS];
    logic [POS_W-1:0]             pos_reg      [CHANNELS];
    logic                         primed_reg   [CHANNELS];
    logic                         lapped_reg   [CHANNELS];
    logic [mma_pkg::SAMPLE_W-1:0] prime_val_reg[CHANNELS];

    logic             upd_hit;
    logic             look_hit;
    logic [CH_W-1:0]  upd_idx;
    logic [CH_W-1:0]  look_idx;
    logic [SUM_W-1:0] cur_sum;
    logic [POS_W-1:0] cur_pos;
    logic             cur_primed;
    logic             cur_lapped;
    logic [mma_pkg::SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0] sum_next;
    logic [POS_W-1:0] pos_next;
    logic             lapped_next;

    assign upd_hit  = ({1'b0, upd_chan} < CHAN_LIMIT);
    assign look_hit = ({1'b0, look_chan} < CHAN_LIMIT);
    assign upd_idx  = upd_hit ? upd_chan[CH_W-1:0] : '0;
    assign look_idx = look_hit ? look_chan[CH_W-1:0] : '0;

    assign cur_sum    = sum_reg[upd_idx];
    assign cur_pos    = pos_reg[upd_idx];
    assign cur_primed = primed_reg[upd_idx];
    assign cur_lapped = lapped_reg[upd_idx];

    // Until the ring has wrapped once, the priming sample stands in for every slot.
    assign oldest = cur_lapped ? ring_rdata : prime_val_reg[upd_idx];

    always_comb
    begin
        if (!cur_primed)
        begin
            sum_next    = SUM_W'(upd_sample) << POS_W;
            pos_next    = '0;
            lapped_next = 1'b0;
        end
        else
        begin
            sum_next    = cur_sum + SUM_W'(upd_sample) - SUM_W'(oldest);
            pos_next    = cur_pos + POS_W'(1);
            lapped_next = cur_lapped | (cur_pos == LAST_POS);
        end
    end

    assign upd_pos            = cur_pos;
    assign upd_ctl.ring_we    = upd_hit & cur_primed;
    assign upd_ctl.primed_now = upd_hit & ~cur_primed;
    assign upd_sum            = upd_hit ? mma_pkg::SUM_OUT_W'(sum_next) : '0;

    // The item being accepted reads the ring at the slot left by the item now retiring.
    always_comb
    begin
        if (upd_en && upd_hit && look_hit && (look_chan == upd_chan))
        begin
            look_pos = pos_next;
        end
        else
        begin
            look_pos = pos_reg[look_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]    <= '0;
                pos_reg[i]    <= '0;
                primed_reg[i] <= 1'b0;
                lapped_reg[i] <= 1'b0;
            end
        end
        else if (upd_en && upd_hit)
        begin
            sum_reg[upd_idx]    <= sum_next;
            pos_reg[upd_idx]    <= pos_next;
            primed_reg[upd_idx] <= 1'b1;
            lapped_reg[upd_idx] <= lapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en && upd_hit && !cur_primed)
        begin
            prime_val_reg[upd_idx] <= upd_sample;
        end
    end

endmodule

`default_nettype wire

/* sv/multichannel_moving_average_top.sv */
// Top level of the multichannel moving-average filter.
//
//   Channel   Handshake                    Payload
//   input     sample_valid / sample_ready  channel, sample
//   result    result_valid / result_ready  channel_out, window_sum_out, primed_now
//
// One transfer in and one result out per cycle when neither side stalls.
// The ring slot is read at the accepting edge, and the per-channel sum update sits between
// the input register and the result register, which it loads when the input stage advances.
// Reset clears every channel's sum, position and flags at once; no clearing pass.
// A stalled result holds the pipeline; input is still taken while a slot is free.
`default_nettype none
`include "multichannel_moving_average_top_macros.svh"

module multichannel_moving_average_top #(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire logic [mma_pkg::CHAN_W-1:0]    channel,
    input  wire logic [mma_pkg::SAMPLE_W-1:0]  sample,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic      [mma_pkg::CHAN_W-1:0]    channel_out,
    output logic      [mma_pkg::SUM_OUT_W-1:0] window_sum_out,
    output logic                               primed_now
);

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W      = $clog2(WINDOW);
    localparam int RING_AW    = CH_W + POS_W;
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam logic [mma_pkg::CHAN_W:0] CHAN_LIMIT = (mma_pkg::CHAN_W + 1)'(CHANNELS);

    logic [mma_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [mma_pkg::CHAN_W-1:0]    s1_chan_reg;
    logic [mma_pkg::SAMPLE_W-1:0]  s1_sample_reg;
    logic [mma_pkg::SAMPLE_W-1:0]  ring_rdata_reg;

    logic                          result_valid_reg;
    logic                          result_valid_next;
    logic [mma_pkg::CHAN_W-1:0]    chan_out_reg;
    logic [mma_pkg::SUM_OUT_W-1:0] sum_out_reg;
    logic                          primed_out_reg;

    logic                          sample_fire;
    logic                          s1_advance;
    logic                          in_hit;
    logic [RING_AW-1:0]            rd_addr;
    logic [RING_AW-1:0]            wr_addr;
    logic [POS_W-1:0]              look_pos;
    logic [POS_W-1:0]              upd_pos;
    mma_pkg::mma_upd_t             upd_ctl;
    logic [mma_pkg::SUM_OUT_W-1:0] upd_sum;

    assign s1_advance   = s1_valid_reg & (~result_valid_reg | result_ready);
    assign sample_ready = ~s1_valid_reg | s1_advance;
    assign sample_fire  = sample_valid & sample_ready;

    assign s1_valid_next     = sample_fire | (s1_valid_reg & ~s1_advance);
    assign result_valid_next = s1_advance | (result_valid_reg & ~result_ready);

    mma_chan_state #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_chan_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (s1_advance),
        .upd_chan   (s1_chan_reg),
        .upd_sample (s1_sample_reg),
        .ring_rdata (ring_rdata_reg),
        .look_chan  (channel),
        .look_pos   (look_pos),
        .upd_pos    (upd_pos),
        .upd_ctl    (upd_ctl),
        .upd_sum    (upd_sum)
    );

    // Channel-major ring layout: WINDOW is a power of two, so the address is a concatenation.
    assign in_hit  = ({1'b0, channel} < CHAN_LIMIT);
    assign rd_addr = in_hit ? {channel[CH_W-1:0], look_pos} : '0;
    assign wr_addr = {s1_chan_reg[CH_W-1:0], upd_pos};

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            ring_rdata_reg <= ring_mem[rd_addr];
        end
        if (s1_advance && upd_ctl.ring_we)
        begin
            ring_mem[wr_addr] <= s1_sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            s1_chan_reg   <= channel;
            s1_sample_reg <= sample;
        end
        if (s1_advance)
        begin
            chan_out_reg   <= s1_chan_reg;
            sum_out_reg    <= upd_sum;
            primed_out_reg <= upd_ctl.primed_now;
        end
    end

    assign result_valid   = result_valid_reg;
    assign channel_out    = chan_out_reg;
    assign window_sum_out = sum_out_reg;
    assign primed_now     = primed_out_reg;

    `MMA_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_chan_reg) && $stable(s1_sample_reg))
    `MMA_ASSERT_NOW(a_full_blocks_input, clk, rst_n, s1_valid_reg && result_valid_reg && !result_ready, !sample_ready)
    `MMA_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, s1_advance, result_valid_reg)
    `MMA_ASSERT_NOW(a_no_write_on_prime, clk, rst_n, s1_advance, !(upd_ctl.ring_we && upd_ctl.primed_now))

endmodule

`default_nettype wire

/* tb/sv/multichannel_moving_average_top_tb.sv */
// Self-checking testbench for the multichannel moving-average filter top level.
`timescale 1ns / 1ps

module multichannel_moving_average_top_tb;

    localparam int CHAN_W      = mma_pkg::CHAN_W;
    localparam int SAMPLE_W    = mma_pkg::SAMPLE_W;
    localparam int SUM_OUT_W   = mma_pkg::SUM_OUT_W;

    localparam int WINDOW      = 8;
    localparam int CHANNELS    = 10;
    localparam int IDLE_PCT    = 7;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [CHAN_W-1:0]    ch;
        logic [SUM_OUT_W-1:0] sum;
        logic                 primed;
    } window_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    logic [CHAN_W-1:0]    channel      = '0;
    logic [SAMPLE_W-1:0]  sample       = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [CHAN_W-1:0]    channel_out;
    logic [SUM_OUT_W-1:0] window_sum_out;
    logic                 primed_now;

    // Filter state kept by the testbench, one entry per channel.
    logic [SAMPLE_W-1:0]  ring_mem [CHANNELS][WINDOW];
    logic [SAMPLE_W-1:0]  prime_val [CHANNELS];
    int                   win_sum [CHANNELS];
    int                   wpos [CHANNELS];
    bit                   primed [CHANNELS];
    bit                   lapped [CHANNELS];

    window_result_t       pending_sums [$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   allow_idle  = 1'b1;

    multichannel_moving_average_top #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .channel        (channel),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .channel_out    (channel_out),
        .window_sum_out (window_sum_out),
        .primed_now     (primed_now)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_sums.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!allow_idle)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic window_result_t compute_window_sum(input logic [CHAN_W-1:0] ch,
                                                          input logic [SAMPLE_W-1:0] x);
        window_result_t r;
        logic [SAMPLE_W-1:0] oldest;
        r.ch     = ch;
        r.sum    = '0;
        r.primed = 1'b0;
        if (ch < CHANNELS)
        begin
            if (!primed[ch])
            begin
                // The first sample fills the whole window with its value.
                prime_val[ch] = x;
                win_sum[ch]   = x * WINDOW;
                wpos[ch]      = 0;
                primed[ch]    = 1'b1;
                lapped[ch]    = 1'b0;
                r.primed      = 1'b1;
            end
            else
            begin
                oldest = lapped[ch] ? ring_mem[ch][wpos[ch]] : prime_val[ch];
                win_sum[ch] = win_sum[ch] + x - oldest;
                ring_mem[ch][wpos[ch]] = x;
                if (wpos[ch] == WINDOW - 1)
                begin
                    wpos[ch]   = 0;
                    lapped[ch] = 1'b1;
                end
                else
                    wpos[ch] = wpos[ch] + 1;
            end
            r.sum = win_sum[ch][SUM_OUT_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual ch %0d sum %0d primed %0d",
                         $time, channel_out, window_sum_out, primed_now);
                error_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (channel_out !== want.ch)
                begin
                    $display("%0t: channel_out mismatch: expected %0d, actual %0d",
                             $time, want.ch, channel_out);
                    error_count++;
                end
                if (window_sum_out !== want.sum)
                begin
                    $display("%0t: window_sum_out mismatch on ch %0d: expected %0d, actual %0d",
                             $time, want.ch, want.sum, window_sum_out);
                    error_count++;
                end
                if (primed_now !== want.primed)
                begin
                    $display("%0t: primed_now mismatch on ch %0d: expected %0d, actual %0d",
                             $time, want.ch, want.primed, primed_now);
                    error_count++;
                end
            end
        end
    end

    // Valid is left high after the transfer so that the next call can keep it up.
    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] x);
        while (allow_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        channel      <= ch;
        sample       <= x;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_sums.push_back(compute_window_sum(ch, x));
    endtask

    task automatic wait_for_drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else
            return SAMPLE_W'($urandom);
    endfunction

    task automatic apply_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_priming_extremes();
        send_sample(4'd0, 10'd1023);
        send_sample(4'd1, 10'd0);
        send_sample(4'd9, 10'd512);
    endtask

    // Drain a full-scale window to zero through the wrap, then read back a lapped slot.
    task automatic test_window_wrap();
        repeat (WINDOW + 1) send_sample(4'd0, 10'd0);
        send_sample(4'd0, 10'd1023);
        send_sample(4'd1, 10'd1023);
        send_sample(4'd1, 10'd1023);
        send_sample(4'd9, 10'd1);
    endtask

    task automatic test_out_of_range();
        send_sample(4'd10, 10'd1023);
        send_sample(4'd15, 10'd0);
        send_sample(4'd12, 10'd341);
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        logic [CHAN_W-1:0] ch;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
                ch = CHAN_W'($urandom_range(15, CHANNELS));
            else
            begin
                ch = CHAN_W'($urandom_range(CHANNELS - 1));
                n++;
            end
            send_sample(ch, random_sample());
        end
    endtask

    // Long run with no idling on either side, mostly on one hot channel at a time,
    // so that back-to-back transfers hit the same channel's state.
    task automatic test_back_to_back_channel(input int count);
        logic [CHAN_W-1:0] hot;
        logic [CHAN_W-1:0] ch;
        allow_idle = 1'b0;
        hot = '0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                hot = CHAN_W'($urandom_range(CHANNELS - 1));
            ch = ($urandom_range(3) == 0) ? CHAN_W'($urandom_range(CHANNELS - 1)) : hot;
            send_sample(ch, random_sample());
        end
        allow_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        test_random_traffic(20);
    endtask

    initial
    begin
        apply_reset();
        test_priming_extremes();
        test_window_wrap();
        test_out_of_range();
        test_random_traffic(900);
        test_back_to_back_channel(450);
        test_drain_pause();
        test_random_traffic(460);
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
